### rtl/btm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_pkg
// Shared sizes, command codes and the control and status structs passed
// between the tape machine datapath and its microcode sequencer.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int TAPE_DEPTH = 32768;
  localparam int PROG_DEPTH = 4096;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int PLEN_W  = $clog2(PROG_DEPTH + 1);
  localparam int CMD_W   = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EXEC = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OPEN  = 2'd1;
  localparam logic [1:0] ERR_CLOSE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INC   = 3'd0,
    CMD_DEC   = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_OUT   = 3'd4,
    CMD_IN    = 3'd5,
    CMD_OPEN  = 3'd6,
    CMD_CLOSE = 3'd7
  } cmd_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_CLEAR,
    UOP_ACCEPT,
    UOP_INC,
    UOP_DEC,
    UOP_LEFT,
    UOP_RIGHT,
    UOP_OUT,
    UOP_IN,
    UOP_FWD_INIT,
    UOP_BWD_INIT,
    UOP_SCAN_FWD,
    UOP_SCAN_BWD,
    UOP_J_DEC,
    UOP_J_TO_CMD,
    UOP_ERR_OPEN,
    UOP_ERR_CLOSE,
    UOP_CMD_INC,
    UOP_LOAD,
    UOP_EMIT
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic prd_scan;
  } ctrl_t;

  typedef struct packed {
    logic req;
    logic load;
    logic done;
    logic cell_nz;
    logic j_end;
    logic j_zero;
    logic fwd_go;
    logic bwd_go;
    logic out_free;
    logic clr_more;
    cmd_t opcode;
  } stat_t;

endpackage

### rtl/btm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/btm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_seq
// Microcode sequencer: a step counter walks a read-only control store, each
// word names a datapath micro-op and an optional conditional jump.
// ----------------------------------------------------------------------------
module btm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  btm_pkg::stat_t stat,
  output btm_pkg::ctrl_t ctrl
);
  import btm_pkg::*;

  localparam int UPC_W = 5;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_REQ,
    C_LOAD,
    C_DONE,
    C_DISPATCH,
    C_CELL_NZ,
    C_CELL_Z,
    C_J_END,
    C_J_ZERO,
    C_FWD_GO,
    C_BWD_GO,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    logic  prd_scan;
    cond_t cond;
    upc_t  target;
  } word_t;

  localparam upc_t U_CLR    = 5'd0;
  localparam upc_t U_IDLE   = 5'd1;
  localparam upc_t U_CHKLD  = 5'd2;
  localparam upc_t U_CHKDN  = 5'd3;
  localparam upc_t U_DECODE = 5'd4;
  localparam upc_t U_INC    = 5'd5;
  localparam upc_t U_DEC    = 5'd6;
  localparam upc_t U_LEFT   = 5'd7;
  localparam upc_t U_RIGHT  = 5'd8;
  localparam upc_t U_OUT    = 5'd9;
  localparam upc_t U_IN     = 5'd10;
  localparam upc_t U_OPEN   = 5'd11;
  localparam upc_t U_CLOSE  = 5'd12;
  localparam upc_t U_FOPEN  = 5'd13;
  localparam upc_t U_FLOOP  = 5'd14;
  localparam upc_t U_FSCAN  = 5'd15;
  localparam upc_t U_FHIT   = 5'd16;
  localparam upc_t U_FERR   = 5'd17;
  localparam upc_t U_BCLOSE = 5'd18;
  localparam upc_t U_BLOOP  = 5'd19;
  localparam upc_t U_BREAD  = 5'd20;
  localparam upc_t U_BSCAN  = 5'd21;
  localparam upc_t U_BHIT   = 5'd22;
  localparam upc_t U_BERR   = 5'd23;
  localparam upc_t U_ADV    = 5'd24;
  localparam upc_t U_LOAD   = 5'd25;
  localparam upc_t U_EMIT   = 5'd26;
  localparam upc_t U_EHOLD  = 5'd27;

  function automatic word_t mk(uop_t u, logic scan, cond_t c, upc_t t);
    word_t w;
    w.uop      = u;
    w.prd_scan = scan;
    w.cond     = c;
    w.target   = t;
    return w;
  endfunction

  function automatic word_t rom(upc_t a);
    word_t w;
    unique case (a)
      U_CLR:    w = mk(UOP_CLEAR,     1'b0, C_CLR_MORE, U_CLR);
      U_IDLE:   w = mk(UOP_ACCEPT,    1'b0, C_NO_REQ,   U_IDLE);
      U_CHKLD:  w = mk(UOP_NONE,      1'b0, C_LOAD,     U_LOAD);
      U_CHKDN:  w = mk(UOP_NONE,      1'b0, C_DONE,     U_EMIT);
      U_DECODE: w = mk(UOP_NONE,      1'b0, C_DISPATCH, U_INC);
      U_INC:    w = mk(UOP_INC,       1'b0, C_ALWAYS,   U_EMIT);
      U_DEC:    w = mk(UOP_DEC,       1'b0, C_ALWAYS,   U_EMIT);
      U_LEFT:   w = mk(UOP_LEFT,      1'b0, C_ALWAYS,   U_EMIT);
      U_RIGHT:  w = mk(UOP_RIGHT,     1'b0, C_ALWAYS,   U_EMIT);
      U_OUT:    w = mk(UOP_OUT,       1'b0, C_ALWAYS,   U_EMIT);
      U_IN:     w = mk(UOP_IN,        1'b0, C_ALWAYS,   U_EMIT);
      U_OPEN:   w = mk(UOP_FWD_INIT,  1'b0, C_ALWAYS,   U_FOPEN);
      U_CLOSE:  w = mk(UOP_BWD_INIT,  1'b0, C_ALWAYS,   U_BCLOSE);
      U_FOPEN:  w = mk(UOP_NONE,      1'b0, C_CELL_NZ,  U_ADV);
      U_FLOOP:  w = mk(UOP_NONE,      1'b1, C_J_END,    U_FERR);
      U_FSCAN:  w = mk(UOP_SCAN_FWD,  1'b0, C_FWD_GO,   U_FLOOP);
      U_FHIT:   w = mk(UOP_J_TO_CMD,  1'b0, C_ALWAYS,   U_EMIT);
      U_FERR:   w = mk(UOP_ERR_OPEN,  1'b0, C_ALWAYS,   U_EMIT);
      U_BCLOSE: w = mk(UOP_NONE,      1'b0, C_CELL_Z,   U_ADV);
      U_BLOOP:  w = mk(UOP_J_DEC,     1'b0, C_J_ZERO,   U_BERR);
      U_BREAD:  w = mk(UOP_NONE,      1'b1, C_NEVER,    U_BREAD);
      U_BSCAN:  w = mk(UOP_SCAN_BWD,  1'b0, C_BWD_GO,   U_BLOOP);
      U_BHIT:   w = mk(UOP_J_TO_CMD,  1'b0, C_ALWAYS,   U_EMIT);
      U_BERR:   w = mk(UOP_ERR_CLOSE, 1'b0, C_ALWAYS,   U_EMIT);
      U_ADV:    w = mk(UOP_CMD_INC,   1'b0, C_ALWAYS,   U_EMIT);
      U_LOAD:   w = mk(UOP_LOAD,      1'b0, C_ALWAYS,   U_EMIT);
      U_EMIT:   w = mk(UOP_EMIT,      1'b0, C_OUT_FREE, U_IDLE);
      U_EHOLD:  w = mk(UOP_NONE,      1'b0, C_ALWAYS,   U_EMIT);
      default:  w = mk(UOP_NONE,      1'b0, C_ALWAYS,   U_IDLE);
    endcase
    return w;
  endfunction

  upc_t  upc_r;
  upc_t  upc_nxt;
  word_t word;
  logic  take;

  assign word          = rom(upc_r);
  assign ctrl.uop      = word.uop;
  assign ctrl.prd_scan = word.prd_scan;

  always_comb begin
    unique case (word.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_CLR_MORE: take = stat.clr_more;
      C_NO_REQ:   take = !stat.req;
      C_LOAD:     take = stat.load;
      C_DONE:     take = stat.done;
      C_DISPATCH: take = 1'b1;
      C_CELL_NZ:  take = stat.cell_nz;
      C_CELL_Z:   take = !stat.cell_nz;
      C_J_END:    take = stat.j_end;
      C_J_ZERO:   take = stat.j_zero;
      C_FWD_GO:   take = stat.fwd_go;
      C_BWD_GO:   take = stat.bwd_go;
      C_OUT_FREE: take = stat.out_free;
      default:    take = 1'b0;
    endcase

    if (word.cond == C_DISPATCH) begin
      upc_nxt = word.target + {{(UPC_W-CMD_W){1'b0}}, stat.opcode};
    end else if (take) begin
      upc_nxt = word.target;
    end else begin
      upc_nxt = upc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/bracket_tape_machine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_tape_machine_core
// Eight-command tape language machine: loads program characters into a
// command store and runs one command per step request, with bracket jumps
// found by scanning the store.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  in_     | in  | program_byte, in_byte, in_eof, pad          | func
//  out_    | out | out_valid, out_byte, input_taken, done_res, | -
//          |     | error_code, load_full, pad                  |
//
//  load request: accept, load check, load, emit; step after the end: accept,
//  load check, done check, emit; a simple command adds decode and its step, a
//  bracket not jumped init, cell test and advance; a jump repeats a store read
//  and a scan step (backward also a decrement) per command scanned.
//  after reset a clearing pass writes zero to every tape cell, one cell a
//  cycle, before the first request is taken.
//  a result waits in the output register; the next request is taken while
//  it waits, and the sequencer holds before its next result until it drains.
// ----------------------------------------------------------------------------
module bracket_tape_machine_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [btm_pkg::IN_TDATA_W-1:0]     in_tdata,  // program_byte, in_byte, in_eof
  input  logic [0:0]                         in_tuser,  // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [btm_pkg::OUT_TDATA_W-1:0]    out_tdata  // out_valid, out_byte,
                                                        // input_taken, done_res,
                                                        // error_code, load_full
);
  import btm_pkg::*;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  ctrl_t ctrl;
  stat_t stat;

  // control state
  logic [PLEN_W-1:0]  len_r, len_nxt;
  logic [PLEN_W-1:0]  cmd_r, cmd_nxt;
  logic [TAPE_AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]         err_r, err_nxt;
  logic [TAPE_AW-1:0] clr_r, clr_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;

  // request and scratch payload
  logic               func_r, func_nxt;
  logic [7:0]         pbyte_r, pbyte_nxt;
  logic [7:0]         ibyte_r, ibyte_nxt;
  logic               eof_r, eof_nxt;
  logic [PLEN_W-1:0]  j_r, j_nxt;
  logic [PLEN_W-1:0]  depth_r, depth_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         ob_r, ob_nxt;
  logic               taken_r, taken_nxt;
  logic               full_r, full_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // memories
  logic               prog_we;
  logic [PROG_AW-1:0] prog_raddr;
  logic [CMD_W-1:0]   prog_wdata;
  logic [CMD_W-1:0]   prog_rdata;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata;
  logic [7:0]         tape_rdata;

  logic               enc_ok;
  cmd_t               enc_code;
  cmd_t               scan_c;
  logic [PLEN_W-1:0]  fwd_depth;
  logic [PLEN_W-1:0]  bwd_depth;
  logic               out_free;
  logic               done;

  btm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  btm_ram #(.WIDTH(CMD_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (len_r[PROG_AW-1:0]),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  btm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (ptr_r),
    .rdata (tape_rdata)
  );

  // command character decode
  always_comb begin
    enc_ok   = 1'b1;
    enc_code = CMD_INC;
    case (pbyte_r)
      CH_PLUS:  enc_code = CMD_INC;
      CH_MINUS: enc_code = CMD_DEC;
      CH_LT:    enc_code = CMD_LEFT;
      CH_GT:    enc_code = CMD_RIGHT;
      CH_DOT:   enc_code = CMD_OUT;
      CH_COMMA: enc_code = CMD_IN;
      CH_LBRK:  enc_code = CMD_OPEN;
      CH_RBRK:  enc_code = CMD_CLOSE;
      default:  enc_ok   = 1'b0;
    endcase
  end

  assign scan_c   = cmd_t'(prog_rdata);
  assign out_free = !out_tvalid_r || out_tready;
  assign done     = (err_r != ERR_NONE) || (cmd_r >= len_r);

  always_comb begin
    fwd_depth = depth_r;
    bwd_depth = depth_r;
    if (scan_c == CMD_OPEN) begin
      fwd_depth = depth_r + PLEN_W'(1);
      bwd_depth = depth_r - PLEN_W'(1);
    end else if (scan_c == CMD_CLOSE) begin
      fwd_depth = depth_r - PLEN_W'(1);
      bwd_depth = depth_r + PLEN_W'(1);
    end
  end

  assign stat.req      = in_tvalid;
  assign stat.load     = (func_r == FUNC_LOAD);
  assign stat.done     = done;
  assign stat.cell_nz  = (tape_rdata != 8'd0);
  assign stat.j_end    = (j_r >= len_r);
  assign stat.j_zero   = (j_r == '0);
  assign stat.fwd_go   = (fwd_depth != '0);
  assign stat.bwd_go   = (bwd_depth != '0);
  assign stat.out_free = out_free;
  assign stat.clr_more = (clr_r != TAPE_AW'(TAPE_DEPTH - 1));
  assign stat.opcode   = scan_c;

  assign prog_raddr = ctrl.prd_scan ? j_r[PROG_AW-1:0] : cmd_r[PROG_AW-1:0];
  assign prog_wdata = enc_code;
  assign prog_we    = (ctrl.uop == UOP_LOAD) && enc_ok &&
                      (len_r != PLEN_W'(PROG_DEPTH));

  assign in_tready  = (ctrl.uop == UOP_ACCEPT);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // tape write port
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = ptr_r;
    tape_wdata = 8'd0;
    unique case (ctrl.uop)
      UOP_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_r;
      end
      UOP_INC: begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata + 8'd1;
      end
      UOP_DEC: begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata - 8'd1;
      end
      UOP_IN: begin
        tape_we    = 1'b1;
        tape_wdata = eof_r ? 8'd0 : ibyte_r;
      end
      default: begin
        tape_we = 1'b0;
      end
    endcase
  end

  // datapath next state
  always_comb begin
    len_nxt        = len_r;
    cmd_nxt        = cmd_r;
    ptr_nxt        = ptr_r;
    err_nxt        = err_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    func_nxt       = func_r;
    pbyte_nxt      = pbyte_r;
    ibyte_nxt      = ibyte_r;
    eof_nxt        = eof_r;
    j_nxt          = j_r;
    depth_nxt      = depth_r;
    ov_nxt         = ov_r;
    ob_nxt         = ob_r;
    taken_nxt      = taken_r;
    full_nxt       = full_r;
    out_tdata_nxt  = out_tdata_r;

    unique case (ctrl.uop)
      UOP_CLEAR: begin
        clr_nxt = clr_r + TAPE_AW'(1);
      end
      UOP_ACCEPT: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser[0];
          pbyte_nxt = in_tdata[7:0];
          ibyte_nxt = in_tdata[15:8];
          eof_nxt   = in_tdata[16];
          ov_nxt    = 1'b0;
          ob_nxt    = 8'd0;
          taken_nxt = 1'b0;
          full_nxt  = 1'b0;
        end
      end
      UOP_INC, UOP_DEC, UOP_CMD_INC: begin
        cmd_nxt = cmd_r + PLEN_W'(1);
      end
      UOP_LEFT: begin
        ptr_nxt = (ptr_r == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : ptr_r - TAPE_AW'(1);
        cmd_nxt = cmd_r + PLEN_W'(1);
      end
      UOP_RIGHT: begin
        ptr_nxt = (ptr_r == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : ptr_r + TAPE_AW'(1);
        cmd_nxt = cmd_r + PLEN_W'(1);
      end
      UOP_OUT: begin
        ov_nxt  = 1'b1;
        ob_nxt  = tape_rdata;
        cmd_nxt = cmd_r + PLEN_W'(1);
      end
      UOP_IN: begin
        taken_nxt = !eof_r;
        cmd_nxt   = cmd_r + PLEN_W'(1);
      end
      UOP_FWD_INIT: begin
        j_nxt     = cmd_r + PLEN_W'(1);
        depth_nxt = PLEN_W'(1);
      end
      UOP_BWD_INIT: begin
        j_nxt     = cmd_r;
        depth_nxt = PLEN_W'(1);
      end
      UOP_SCAN_FWD: begin
        depth_nxt = fwd_depth;
        if (fwd_depth != '0) begin
          j_nxt = j_r + PLEN_W'(1);
        end
      end
      UOP_SCAN_BWD: begin
        depth_nxt = bwd_depth;
      end
      UOP_J_DEC: begin
        j_nxt = j_r - PLEN_W'(1);
      end
      UOP_J_TO_CMD: begin
        cmd_nxt = j_r + PLEN_W'(1);
      end
      UOP_ERR_OPEN: begin
        err_nxt = ERR_OPEN;
      end
      UOP_ERR_CLOSE: begin
        err_nxt = ERR_CLOSE;
      end
      UOP_LOAD: begin
        if (enc_ok) begin
          if (len_r != PLEN_W'(PROG_DEPTH)) begin
            len_nxt = len_r + PLEN_W'(1);
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      UOP_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, full_r, err_r, done, taken_r, ob_r, ov_r};
        end
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      cmd_r        <= '0;
      ptr_r        <= '0;
      err_r        <= ERR_NONE;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      cmd_r        <= cmd_nxt;
      ptr_r        <= ptr_nxt;
      err_r        <= err_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    pbyte_r     <= pbyte_nxt;
    ibyte_r     <= ibyte_nxt;
    eof_r       <= eof_nxt;
    j_r         <= j_nxt;
    depth_r     <= depth_nxt;
    ov_r        <= ov_nxt;
    ob_r        <= ob_nxt;
    taken_r     <= taken_nxt;
    full_r      <= full_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the bracket tape machine. A directed table covers
// the empty store, dropped bytes, cell wrap, pointer wrap, input end and a
// forward jump. Random programs follow: loops whose bodies end in a read, so
// the stimulus can always steer them out. The run ends by filling the store
// and stopping on an unmatched bracket. Every result is compared with a
// machine model kept in this file, or with a directed row's known result.
// ----------------------------------------------------------------------------
module testbench;
  import btm_pkg::*;

  localparam logic [7:0] CH_INC   = "+";
  localparam logic [7:0] CH_DEC   = "-";
  localparam logic [7:0] CH_LEFT  = "<";
  localparam logic [7:0] CH_RIGHT = ">";
  localparam logic [7:0] CH_OUT   = ".";
  localparam logic [7:0] CH_IN    = ",";
  localparam logic [7:0] CH_OPEN  = "[";
  localparam logic [7:0] CH_CLOSE = "]";

  typedef struct packed {
    logic       load_full;
    logic [1:0] error_code;
    logic       done_res;
    logic       input_taken;
    logic [7:0] out_byte;
    logic       out_valid;
  } tape_result_t;

  typedef struct packed {
    logic         func;
    logic [7:0]   program_byte;
    logic [7:0]   in_byte;
    logic         in_eof;
    logic         known;
    tape_result_t result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  cmd_t              prog_mem [PROG_DEPTH];
  bit   [7:0]        tape_mem [TAPE_DEPTH];
  logic [PLEN_W-1:0] prog_len;
  logic [PLEN_W-1:0] cmd_idx;
  logic [TAPE_AW-1:0] cell_ptr;
  logic [1:0]        halt_err;

  tape_result_t expected_results[$];
  stim_row_t    dir_rows[$];
  int           mismatches;
  int           accepted_count;

  bracket_tape_machine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit decode_char(input logic [7:0] ch, output cmd_t c);
    decode_char = 1'b1;
    c = CMD_INC;
    case (ch)
      CH_INC: c = CMD_INC;
      CH_DEC: c = CMD_DEC;
      CH_LEFT: c = CMD_LEFT;
      CH_RIGHT: c = CMD_RIGHT;
      CH_OUT: c = CMD_OUT;
      CH_IN: c = CMD_IN;
      CH_OPEN: c = CMD_OPEN;
      CH_CLOSE: c = CMD_CLOSE;
      default: decode_char = 1'b0;
    endcase
  endfunction

  function automatic bit machine_done();
    return halt_err != ERR_NONE || cmd_idx >= prog_len;
  endfunction

  function automatic tape_result_t tape_step(input stim_row_t r);
    tape_result_t      res;
    cmd_t              c;
    logic [PLEN_W-1:0] nxt;
    int                j;
    int                depth;
    res = '0;
    if (r.func == FUNC_LOAD) begin
      if (decode_char(r.program_byte, c)) begin
        if (prog_len < PROG_DEPTH) begin
          prog_mem[prog_len] = c;
          prog_len = prog_len + 1'b1;
        end else begin
          res.load_full = 1'b1;
        end
      end
    end else if (!machine_done()) begin
      nxt = cmd_idx + 1'b1;
      case (prog_mem[cmd_idx])
        CMD_INC: tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
        CMD_DEC: tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
        CMD_LEFT: cell_ptr = cell_ptr - 1'b1;
        CMD_RIGHT: cell_ptr = cell_ptr + 1'b1;
        CMD_OUT: begin
          res.out_valid = 1'b1;
          res.out_byte = tape_mem[cell_ptr];
        end
        CMD_IN: begin
          tape_mem[cell_ptr] = r.in_eof ? 8'd0 : r.in_byte;
          res.input_taken = !r.in_eof;
        end
        CMD_OPEN: begin
          if (tape_mem[cell_ptr] == 8'd0) begin
            j = cmd_idx + 1;
            depth = 1;
            while (j < prog_len && depth != 0) begin
              if (prog_mem[j] == CMD_OPEN) depth++;
              else if (prog_mem[j] == CMD_CLOSE) depth--;
              if (depth != 0) j++;
            end
            if (depth != 0) begin
              halt_err = ERR_OPEN;
              nxt = cmd_idx;
            end else begin
              nxt = PLEN_W'(j + 1);
            end
          end
        end
        default: begin
          if (tape_mem[cell_ptr] != 8'd0) begin
            j = cmd_idx;
            depth = 1;
            while (j > 0 && depth != 0) begin
              j--;
              if (prog_mem[j] == CMD_CLOSE) depth++;
              else if (prog_mem[j] == CMD_OPEN) depth--;
            end
            if (depth != 0) begin
              halt_err = ERR_CLOSE;
              nxt = cmd_idx;
            end else begin
              nxt = PLEN_W'(j + 1);
            end
          end
        end
      endcase
      cmd_idx = nxt;
    end
    res.done_res = machine_done();
    res.error_code = halt_err;
    return res;
  endfunction

  function automatic stim_row_t table_row(
    input logic func, input logic [7:0] pb, input logic [7:0] ib, input logic eof,
    input logic known, input logic ov, input logic [7:0] ob, input logic tk,
    input logic dn, input logic [1:0] er, input logic fl);
    stim_row_t r;
    r.func = func;
    r.program_byte = pb;
    r.in_byte = ib;
    r.in_eof = eof;
    r.known = known;
    r.result.out_valid = ov;
    r.result.out_byte = ob;
    r.result.input_taken = tk;
    r.result.done_res = dn;
    r.result.error_code = er;
    r.result.load_full = fl;
    return r;
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 5))
      0: return CH_INC;
      1: return CH_DEC;
      2: return CH_LEFT;
      3: return CH_RIGHT;
      4: return CH_OUT;
      default: return CH_IN;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    cmd_t       c;
    do b = rand_byte(); while (decode_char(b, c));
    return b;
  endfunction

  function automatic bit sender_idles();
    if (accepted_count < 260) return $urandom_range(0, 99) < 38;
    if (accepted_count < 520) return $urandom_range(0, 99) < 72;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (accepted_count < 260) return $urandom_range(0, 99) < 72;
    if (accepted_count < 520) return $urandom_range(0, 99) < 38;
    return 1'b0;
  endfunction

  function automatic void check_result(input tape_result_t got);
    tape_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: valid=%0d byte=%02h taken=%0d done=%0d err=%0d full=%0d",
                 got.out_valid, got.out_byte, got.input_taken, got.done_res,
                 got.error_code, got.load_full);
      return;
    end
    want = expected_results.pop_front();
    if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
        got.input_taken !== want.input_taken || got.done_res !== want.done_res ||
        got.error_code !== want.error_code || got.load_full !== want.load_full) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: valid=%0d byte=%02h taken=%0d done=%0d err=%0d full=%0d",
                 want.out_valid, want.out_byte, want.input_taken, want.done_res,
                 want.error_code, want.load_full);
        $display("         got: valid=%0d byte=%02h taken=%0d done=%0d err=%0d full=%0d",
                 got.out_valid, got.out_byte, got.input_taken, got.done_res,
                 got.error_code, got.load_full);
      end
    end
  endfunction

  // result side: sample at the edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata[13:0]);
    out_tready <= !receiver_stalls();
  end

  task automatic send_request(input stim_row_t r);
    tape_result_t want;
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.func;
    in_tdata <= {7'd0, r.in_eof, r.in_byte, r.program_byte};
    do @(posedge clk); while (!in_tready);
    want = tape_step(r);
    if (r.known) want = r.result;
    expected_results.push_back(want);
    accepted_count++;
  endtask

  task automatic send_item(input logic func, input logic [7:0] pb, input logic [7:0] ib,
                           input logic eof);
    send_request(table_row(func, pb, ib, eof, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, ERR_NONE, 1'b0));
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // every loop body ends in a read, so forcing end of input breaks any loop
  task automatic run_random_program();
    logic [7:0] prog_chars[$];
    int         open_loops;
    int         r;
    int         steps;
    open_loops = 0;
    repeat ($urandom_range(4, 16)) begin
      r = $urandom_range(0, 9);
      if (r < 2 && open_loops < 3) begin
        prog_chars.push_back(CH_OPEN);
        open_loops++;
      end else if (r < 4 && open_loops > 0) begin
        prog_chars.push_back(CH_IN);
        prog_chars.push_back(CH_CLOSE);
        open_loops--;
      end else begin
        prog_chars.push_back(plain_char());
      end
    end
    while (open_loops > 0) begin
      prog_chars.push_back(CH_IN);
      prog_chars.push_back(CH_CLOSE);
      open_loops--;
    end
    repeat ($urandom_range(0, 2))
      send_item(FUNC_EXEC, rand_byte(), rand_byte(), rand_bit());
    foreach (prog_chars[i]) begin
      if ($urandom_range(0, 4) == 0)
        send_item(FUNC_LOAD, noise_byte(), rand_byte(), rand_bit());
      send_item(FUNC_LOAD, prog_chars[i], rand_byte(), rand_bit());
    end
    steps = 0;
    while (!machine_done()) begin
      send_item(FUNC_EXEC, rand_byte(), rand_byte(),
                steps > 60 ? 1'b1 : ($urandom_range(0, 3) == 0));
      steps++;
    end
  endtask

  initial begin
    int         random_start;
    logic [1:0] err_kind;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    prog_len = '0;
    cmd_idx = '0;
    cell_ptr = '0;
    halt_err = ERR_NONE;
    mismatches = 0;
    accepted_count = 0;

    //                            func       pbyte     ibyte  eof  known ov obyte tk dn err fl
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 1, 0, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, 8'h00,    8'hFF, 1, 1, 0, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, 8'hFF,    8'h00, 0, 1, 0, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_INC,   8'h00, 0, 1, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 1, 0, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_OUT,   8'h00, 0, 1, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 1, 1, 8'h01, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_IN,    8'h00, 0, 1, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'hFF, 0, 1, 0, 8'h00, 1, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_OUT,   8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 1, 1, 8'hFF, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_INC,   8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_DEC,   8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_LEFT,  8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_OUT,   8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 1, 1, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_IN,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h5A, 1, 1, 0, 8'h00, 0, 1, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_OPEN,  8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_INC,   8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_CLOSE, 8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_LOAD, CH_RIGHT, 8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));
    dir_rows.push_back(table_row(FUNC_EXEC, 8'h00,    8'h00, 0, 0, 0, 8'h00, 0, 0, ERR_NONE, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    random_start = accepted_count;
    while (accepted_count - random_start < 650) begin
      run_random_program();
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    // fill the store behind a bracket that can never match, then run into it
    hold_until_drained();
    err_kind = $urandom_range(0, 1) ? ERR_OPEN : ERR_CLOSE;
    send_item(FUNC_LOAD, CH_IN, rand_byte(), rand_bit());
    send_item(FUNC_LOAD, err_kind == ERR_OPEN ? CH_OPEN : CH_CLOSE, rand_byte(), rand_bit());
    while (prog_len < PROG_DEPTH)
      send_item(FUNC_LOAD, plain_char(), rand_byte(), rand_bit());
    send_item(FUNC_LOAD, CH_INC, 8'h00, 1'b0);
    send_item(FUNC_LOAD, noise_byte(), 8'h00, 1'b0);
    send_item(FUNC_LOAD, CH_OPEN, 8'h00, 1'b0);
    send_item(FUNC_EXEC, 8'h00, 8'($urandom_range(1, 255)), err_kind == ERR_OPEN);
    send_item(FUNC_EXEC, 8'h00, rand_byte(), rand_bit());
    repeat (2)
      send_item(FUNC_EXEC, rand_byte(), rand_byte(), rand_bit());
    send_item(FUNC_LOAD, CH_OUT, 8'h00, 1'b0);

    hold_until_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("bracket_tape_machine_core regression: pass");
    end else begin
      $display("bracket_tape_machine_core regression: fail");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("bracket_tape_machine_core regression: fail");
    $finish;
  end

endmodule
